[rtl/free_location_list_defines.svh]
// Assertion macros shared by the free location list RTL.
`ifndef FREE_LOCATION_LIST_DEFINES_SVH
`define FREE_LOCATION_LIST_DEFINES_SVH

// Clocked check, held off while reset is asserted (reset is active low).
`define FLL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define FLL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/fll_pkg.sv]
// Shared status codes and controller/datapath interface types.
package fll_pkg;

    // Result status codes
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_EMPTY = 3'd1;
    localparam logic [2:0] ST_DUP   = 3'd2;
    localparam logic [2:0] ST_FULL  = 3'd3;
    localparam logic [2:0] ST_ZERO  = 3'd4;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       load;    // beat accepted: latch key, start read at head
        logic       step;    // advance the duplicate scan by one entry
        logic       take;    // pop head, report the read data
        logic       append;  // write latched key at tail
        logic       post;    // report status with no change to the list
        logic [2:0] status;  // status code reported by post
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic count_zero;
        logic count_full;
        logic key_zero;   // incoming key is zero after reduction
        logic hit;        // entry read last cycle matches latched key
        logic last;       // entry read last cycle is the last held one
    } t_flags;

endpackage

[rtl/fll_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module fll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/fll_dp.sv]
// Datapath: ring pointers, count, key latch, store and result registers.
`include "free_location_list_defines.svh"

module fll_dp #(
    parameter int CAPACITY = 128,
    parameter int KEY_BITS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fll_pkg::t_cmd  i_cmd,
    output fll_pkg::t_flags o_flags,
    input  logic [31:0]    i_new_key,
    output logic           o_done,
    output logic [31:0]    o_taken_key,
    output logic [2:0]     o_status,
    output logic [7:0]     o_entry_count
);

    localparam int StoreW = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam int IdxW   = $clog2(CAPACITY);
    localparam int CntW   = $clog2(CAPACITY + 1);

    logic [IdxW-1:0]   r_head, n_head;
    logic [IdxW-1:0]   r_tail, n_tail;
    logic [CntW-1:0]   r_count, n_count;
    logic [IdxW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0]   r_left, n_left;
    logic [StoreW-1:0] r_key, n_key;
    logic              r_done;
    logic [31:0]       r_taken, n_taken;
    logic [2:0]        r_status, n_status;
    logic [7:0]        r_entry_count;

    logic [StoreW-1:0] in_key;
    logic [StoreW-1:0] rd_data;
    logic [IdxW-1:0]   rd_addr;
    logic [CntW+7:0]   count_ext;
    logic [StoreW+31:0] rd_ext;

    // Ring index increment with wrap at CAPACITY
    function automatic logic [IdxW-1:0] wrap_inc(input logic [IdxW-1:0] p);
        logic [IdxW-1:0] q;
        if (p == IdxW'(CAPACITY - 1)) begin
            q = '0;
        end else begin
            q = p + 1'b1;
        end
        return q;
    endfunction

    assign in_key    = i_new_key[StoreW-1:0];
    assign rd_addr   = i_cmd.load ? r_head : r_rd_ptr;
    assign rd_ext    = {32'b0, rd_data};
    assign count_ext = {8'b0, n_count};

    fll_ram #(
        .WIDTH(StoreW),
        .DEPTH(CAPACITY)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (i_cmd.append),
        .i_waddr(r_tail),
        .i_wdata(r_key),
        .i_raddr(rd_addr),
        .o_rdata(rd_data)
    );

    // Flags for the controller
    assign o_flags.count_zero = (r_count == '0);
    assign o_flags.count_full = (r_count == CntW'(CAPACITY));
    assign o_flags.key_zero   = (in_key == '0);
    assign o_flags.hit        = (rd_data == r_key);
    assign o_flags.last       = (r_left == CntW'(1));

    // Next-state logic
    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_rd_ptr = r_rd_ptr;
        n_left   = r_left;
        n_key    = r_key;
        n_taken  = 32'b0;
        n_status = fll_pkg::ST_OK;
        if (i_cmd.load) begin
            n_key    = in_key;
            n_rd_ptr = wrap_inc(r_head);
            n_left   = r_count;
        end
        if (i_cmd.step) begin
            n_rd_ptr = wrap_inc(r_rd_ptr);
            n_left   = r_left - 1'b1;
        end
        if (i_cmd.take) begin
            n_head  = wrap_inc(r_head);
            n_count = r_count - 1'b1;
            n_taken = rd_ext[31:0];
        end
        if (i_cmd.append) begin
            n_tail  = wrap_inc(r_tail);
            n_count = r_count + 1'b1;
        end
        if (i_cmd.post) begin
            n_status = i_cmd.status;
        end
    end

    // Control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_done  <= i_cmd.take | i_cmd.append | i_cmd.post;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rd_ptr      <= n_rd_ptr;
        r_left        <= n_left;
        r_key         <= n_key;
        r_taken       <= n_taken;
        r_status      <= n_status;
        r_entry_count <= count_ext[7:0];
    end

    assign o_done        = r_done;
    assign o_taken_key   = r_taken;
    assign o_status      = r_status;
    assign o_entry_count = r_entry_count;

    // Checks
    `FLL_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CntW'(CAPACITY),
        "held count exceeds capacity")
    `FLL_ASSERT(a_count_moves_with_beat, i_clk, i_rst_n, !$stable(r_count) |-> r_done,
        "held count changed without a result beat")
    `FLL_ASSERT(a_ring_ends, i_clk, i_rst_n,
        (r_count == '0 || r_count == CntW'(CAPACITY)) |-> (r_head == r_tail),
        "head and tail disagree on an empty or full list")

endmodule

[rtl/fll_ctrl.sv]
// Controller: sequences take, duplicate scan and append.
module fll_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_mode,
    input  fll_pkg::t_flags i_flags,
    output fll_pkg::t_cmd   o_cmd,
    output logic            o_busy
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_TAKE   = 4'b0010,
        S_SCAN   = 4'b0100,
        S_APPEND = 4'b1000
    } t_state;

    t_state        r_state, n_state;
    fll_pkg::t_cmd cmd;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (!i_mode) begin
                        if (i_flags.count_zero) begin
                            cmd.post   = 1'b1;
                            cmd.status = fll_pkg::ST_EMPTY;
                        end else begin
                            cmd.load = 1'b1;
                            n_state  = S_TAKE;
                        end
                    end else if (i_flags.key_zero) begin
                        cmd.post   = 1'b1;
                        cmd.status = fll_pkg::ST_ZERO;
                    end else if (i_flags.count_zero) begin
                        cmd.load = 1'b1;
                        n_state  = S_APPEND;
                    end else begin
                        cmd.load = 1'b1;
                        n_state  = S_SCAN;
                    end
                end
            end
            S_TAKE: begin
                cmd.take = 1'b1;
                n_state  = S_IDLE;
            end
            S_SCAN: begin
                if (i_flags.hit) begin
                    cmd.post   = 1'b1;
                    cmd.status = fll_pkg::ST_DUP;
                    n_state    = S_IDLE;
                end else if (i_flags.last) begin
                    if (i_flags.count_full) begin
                        cmd.post   = 1'b1;
                        cmd.status = fll_pkg::ST_FULL;
                    end else begin
                        cmd.append = 1'b1;
                    end
                    n_state = S_IDLE;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            S_APPEND: begin
                cmd.append = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);

endmodule

[rtl/free_location_list.sv]
// Top level: free location list with duplicate check on release.
//
//  channel  | handshake           | beat fields
//  ---------+---------------------+------------------------------------------
//  command  | start, busy         | i_mode, i_new_key
//  result   | o_done (strobe)     | o_taken_key, o_status, o_entry_count
//
// A take from an empty list and a zero-key release load the result register
// straight from idle, so their strobe comes in the cycle after the start beat; a
// take passes through S_TAKE first. A release scans the held entries through the
// single store read port, one entry a cycle, until a match or the last held one,
// then loads the result; a release into an empty list goes through S_APPEND.
// busy falls as the result register loads, so a new beat may start in the
// strobe cycle. Synchronous active-low reset empties the list; the store
// itself is not cleared. The result is held one cycle only; no back-pressure.
module free_location_list #(
    parameter int CAPACITY = 128,
    parameter int KEY_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_mode,
    input  logic [31:0] i_new_key,
    output logic        o_done,
    output logic [31:0] o_taken_key,
    output logic [2:0]  o_status,
    output logic [7:0]  o_entry_count
);

    fll_pkg::t_cmd   cmd;
    fll_pkg::t_flags flags;

    fll_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_mode (i_mode),
        .i_flags(flags),
        .o_cmd  (cmd),
        .o_busy (busy)
    );

    fll_dp #(
        .CAPACITY(CAPACITY),
        .KEY_BITS(KEY_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_flags      (flags),
        .i_new_key    (i_new_key),
        .o_done       (o_done),
        .o_taken_key  (o_taken_key),
        .o_status     (o_status),
        .o_entry_count(o_entry_count)
    );

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the free location list: directed, fill/drain, random traffic.
module tb;

    localparam int CAPACITY   = 128;
    localparam int WATCH_MAX  = 5000;   // idle cycles before the run is declared hung
    localparam int SETTLE_CYC = CAPACITY + 8;

    typedef struct {
        logic [31:0] taken_key;
        logic [2:0]  status;
        logic [7:0]  entry_count;
    } t_loc_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_mode;
    logic [31:0] i_new_key;
    logic        o_done;
    logic [31:0] o_taken_key;
    logic [2:0]  o_status;
    logic [7:0]  o_entry_count;

    // predictor state: the held locations, oldest first
    logic [31:0]  held_keys[$];
    t_loc_result  pending_results[$];

    int  n_beats;
    int  n_results;
    int  n_errors;
    int  status_seen[5];
    int  watch_cnt;
    bit  idle_enable;

    free_location_list #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (32)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_mode        (i_mode),
        .i_new_key     (i_new_key),
        .o_done        (o_done),
        .o_taken_key   (o_taken_key),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // expected outcome of one take or release; updates the held list
    function automatic t_loc_result predict_location_step(bit mode, logic [31:0] key);
        t_loc_result r;
        bit          held;
        r.taken_key = '0;
        held = 1'b0;
        if (!mode) begin
            if (held_keys.size() == 0) begin
                r.status = fll_pkg::ST_EMPTY;
            end else begin
                r.taken_key = held_keys.pop_front();
                r.status = fll_pkg::ST_OK;
            end
        end else if (key == '0) begin
            r.status = fll_pkg::ST_ZERO;
        end else begin
            foreach (held_keys[i]) begin
                if (held_keys[i] == key)
                    held = 1'b1;
            end
            if (held) begin
                r.status = fll_pkg::ST_DUP;
            end else if (held_keys.size() >= CAPACITY) begin
                r.status = fll_pkg::ST_FULL;
            end else begin
                held_keys.push_back(key);
                r.status = fll_pkg::ST_OK;
            end
        end
        r.entry_count = 8'(held_keys.size());
        return r;
    endfunction

    // key mix: fresh random, already held, small values (collisions), zero
    function automatic logic [31:0] pick_key();
        logic [31:0] k;
        case ($urandom_range(0, 9))
            0: k = '0;
            1, 2: begin
                if (held_keys.size() != 0)
                    k = held_keys[$urandom_range(0, held_keys.size() - 1)];
                else
                    k = $urandom;
            end
            3: k = $urandom_range(1, 200);
            default: k = $urandom;
        endcase
        return k;
    endfunction

    // drive one beat and hold it until the block takes it
    task automatic send_beat(bit mode, logic [31:0] key);
        start     <= 1'b1;
        i_mode    <= mode;
        i_new_key <= key;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(predict_location_step(mode, key));
        n_beats++;
    endtask

    // random sender gap after a beat
    task automatic pace();
        if (idle_enable && $urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    // stop sending until every outstanding result is back
    task automatic wait_all_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_beat(int release_pct);
        send_beat($urandom_range(1, 100) <= release_pct, pick_key());
        pace();
    endtask

    task automatic test_directed_cases();
        send_beat(1'b0, 32'h0000_0000);  // take from empty list
        send_beat(1'b0, 32'hFFFF_FFFF);  // take from empty, key ignored
        send_beat(1'b1, 32'h0000_0000);  // zero key
        send_beat(1'b1, 32'hFFFF_FFFF);
        send_beat(1'b1, 32'h0000_0001);
        send_beat(1'b1, 32'h8000_0000);
        send_beat(1'b1, 32'h0000_0001);  // duplicate
        send_beat(1'b1, 32'hFFFF_FFFF);  // duplicate of head
        send_beat(1'b1, 32'hAAAA_AAAA);
        send_beat(1'b1, 32'h5555_5555);
        send_beat(1'b0, 32'h1234_5678);  // take with nonzero key
        pace();
        send_beat(1'b1, 32'hFFFF_FFFF);  // released again after being taken
        send_beat(1'b0, 32'h0000_0000);
        send_beat(1'b0, 32'h0000_0000);
        send_beat(1'b0, 32'h0000_0000);
        send_beat(1'b0, 32'h0000_0000);
        send_beat(1'b0, 32'h0000_0000);
        send_beat(1'b0, 32'h0000_0000);  // empty again
        send_beat(1'b1, 32'h0000_0000);
        wait_all_results();
    endtask

    // fill to capacity, hit full and duplicate-on-full, then drain to empty
    task automatic test_fill_and_drain(int rounds);
        int guard;
        repeat (rounds) begin
            guard = 0;
            while (held_keys.size() < CAPACITY && guard < 1000) begin
                random_beat(90);
                guard++;
            end
            repeat (12) random_beat(100);
            guard = 0;
            while (held_keys.size() != 0 && guard < 1000) begin
                random_beat(12);
                guard++;
            end
            repeat (4) random_beat(0);
            if ($urandom_range(0, 1) == 0)
                idle_enable = ~idle_enable;
        end
    endtask

    // balanced traffic with stretches that have no sender gaps
    task automatic test_mixed_traffic(int n);
        for (int i = 0; i < n; i++) begin
            if (i % 48 == 0)
                idle_enable = ($urandom_range(0, 2) != 0);
            random_beat(55);
        end
    endtask

    // sender holds off mid-run until the list has answered everything
    task automatic test_drain_pause();
        repeat (30) random_beat(70);
        wait_all_results();
        repeat (30) random_beat(40);
        wait_all_results();
    endtask

    // last part: back-to-back beats, no gaps
    task automatic test_back_to_back(int n);
        idle_enable = 1'b0;
        repeat (n) random_beat(55);
    endtask

    // compare each result strobe with the oldest expectation
    always @(posedge i_clk) begin
        t_loc_result exp_r;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: taken_key %h status %0d count %0d",
                       o_taken_key, o_status, o_entry_count);
                n_errors++;
            end else begin
                exp_r = pending_results.pop_front();
                n_results++;
                if (o_status < 5)
                    status_seen[o_status]++;
                if (o_taken_key !== exp_r.taken_key) begin
                    $error("taken_key mismatch: expected %h, got %h",
                           exp_r.taken_key, o_taken_key);
                    n_errors++;
                end
                if (o_status !== exp_r.status) begin
                    $error("status mismatch: expected %0d, got %0d", exp_r.status, o_status);
                    n_errors++;
                end
                if (o_entry_count !== exp_r.entry_count) begin
                    $error("entry_count mismatch: expected %0d, got %0d",
                           exp_r.entry_count, o_entry_count);
                    n_errors++;
                end
            end
        end
    end

    // watchdog: cycles with neither an accepted beat nor a result
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            watch_cnt <= 0;
        end else if (watch_cnt >= WATCH_MAX) begin
            $display("timeout: no progress for %0d cycles", WATCH_MAX);
            $display("DONE: errors detected");
            $finish;
        end else begin
            watch_cnt <= watch_cnt + 1;
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_mode      <= 1'b0;
        i_new_key   <= '0;
        watch_cnt   = 0;
        n_beats     = 0;
        n_results   = 0;
        n_errors    = 0;
        idle_enable = 1'b1;
        foreach (status_seen[i]) status_seen[i] = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_fill_and_drain(2);
        test_drain_pause();
        test_mixed_traffic(630);
        test_back_to_back(200);

        wait_all_results();
        repeat (SETTLE_CYC) @(posedge i_clk);

        $display("Run covered %0d beats, %0d results checked", n_beats, n_results);
        $display("  status ok %0d, empty %0d, duplicate %0d, full %0d, zero key %0d",
                 status_seen[fll_pkg::ST_OK], status_seen[fll_pkg::ST_EMPTY],
                 status_seen[fll_pkg::ST_DUP], status_seen[fll_pkg::ST_FULL],
                 status_seen[fll_pkg::ST_ZERO]);
        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
